// File: src/nddet_pkg.sv
package nddet_pkg;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_CHAIN,
      ST_LINK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_step;
      logic accept;
      logic rd_head;
      logic rd_link;
      logic refresh;
      logic alloc_head;
      logic alloc_link;
      logic link_wr;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic head_hit;
      logic stale;
      logic same;
      logic link_end;
      logic full;
      logic rsp_free;
   } status_type;

   localparam int ValueWidth  = 32;
   localparam int WindowWidth = 16;

endpackage

// File: src/nddet_channels.sv
interface nddet_req_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     value;
   logic                   last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface nddet_rsp_if;
   logic valid;
   logic ready;
   logic match;
   logic found;
   logic overflow;
   logic done_res;

   modport source (output valid, output match, output found, output overflow,
                   output done_res, input ready);
   modport sink   (input valid, input match, input found, input overflow,
                   input done_res, output ready);
endinterface

interface nddet_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] window_k;

   modport source (output valid, output window_k, input ready);
   modport sink   (input valid, input window_k, output ready);
endinterface

// File: src/nddet_ctrl.sv
module nddet_ctrl
   import nddet_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (st.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            state_in = st.head_hit ? ST_CHAIN : ST_DONE;
         end
         ST_CHAIN: begin
            if (st.stale || st.same) begin
               state_in = ST_DONE;
            end else if (st.link_end) begin
               state_in = st.full ? ST_DONE : ST_LINK;
            end
         end
         ST_LINK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (st.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_HEAD: begin
            cmd.rd_head    = st.head_hit;
            cmd.alloc_head = !st.head_hit;
         end
         ST_CHAIN: begin
            // The first entry of a chain may be left over from an earlier array.
            if (st.stale) begin
               cmd.alloc_head = 1'b1;
            end else if (st.same) begin
               cmd.refresh = 1'b1;
            end else if (st.link_end) begin
               cmd.alloc_link = 1'b1;
            end else begin
               cmd.rd_link = 1'b1;
            end
         end
         ST_LINK: begin
            cmd.link_wr = 1'b1;
         end
         ST_DONE: begin
            cmd.finish = st.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: src/nddet_dp.sv
module nddet_dp
   import nddet_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024,
   parameter int POSITION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                st,
   input  logic [ValueWidth-1:0]     req_value,
   input  logic                      req_last,
   input  logic                      csr_valid,
   input  logic [WindowWidth-1:0]    csr_window_k,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_match,
   output logic                      rsp_found,
   output logic                      rsp_overflow,
   output logic                      rsp_done_res
);

   localparam int IdxW  = $clog2(TABLE_ENTRIES);
   localparam int PtrW  = IdxW + 1;
   localparam int CmpW  = (POSITION_BITS > WindowWidth) ? POSITION_BITS : WindowWidth;
   localparam logic [PtrW-1:0]          Empty  = PtrW'(TABLE_ENTRIES);
   localparam logic [POSITION_BITS-1:0] PosMax = '1;

   typedef struct packed {
      logic [ValueWidth-1:0]    value;
      logic [POSITION_BITS-1:0] position;
      logic [PtrW-1:0]          link;
   } entry_type;

   logic [PtrW-1:0] head_mem [TABLE_ENTRIES];
   entry_type       ent_mem  [TABLE_ENTRIES];

   logic [WindowWidth-1:0]   window_k_ff;
   logic [ValueWidth-1:0]    value_ff;
   logic                     last_ff;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] counter_ff;
   logic [PtrW-1:0]          used_ff;
   logic                     found_ff;
   logic                     ovf_ff;
   logic                     match_ff;
   logic                     first_ff;
   logic [IdxW-1:0]          cur_ff;
   logic [PtrW-1:0]          alloc_ff;
   logic [IdxW-1:0]          clr_idx_ff;
   logic [PtrW-1:0]          head_rd_ff;
   entry_type                ent_rd_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_match_ff;
   logic                     rsp_found_ff;
   logic                     rsp_overflow_ff;
   logic                     rsp_done_ff;

   logic                     full;
   logic                     alloc;
   logic [POSITION_BITS-1:0] span;
   logic                     near;
   logic                     head_we;
   logic [IdxW-1:0]          head_wa;
   logic [PtrW-1:0]          head_wd;
   logic                     ent_we;
   logic [IdxW-1:0]          ent_wa;
   entry_type                ent_wd;
   logic                     ent_re;
   logic [IdxW-1:0]          ent_ra;

   assign full  = (used_ff == Empty);
   assign alloc = cmd.alloc_head || cmd.alloc_link;
   assign span  = pos_ff - ent_rd_ff.position;
   assign near  = (CmpW'(span) <= CmpW'(window_k_ff));

   always_comb begin
      st.clr_last = (clr_idx_ff == IdxW'(TABLE_ENTRIES - 1));
      // Any head at or past the fill count is empty for this array.
      st.head_hit = (head_rd_ff < used_ff);
      st.stale    = first_ff && (ent_rd_ff.value[IdxW-1:0] != value_ff[IdxW-1:0]);
      st.same     = (ent_rd_ff.value == value_ff);
      st.link_end = (ent_rd_ff.link >= Empty);
      st.full     = full;
      st.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   // Head store port.
   always_comb begin
      head_we = 1'b0;
      head_wa = clr_idx_ff;
      head_wd = Empty;
      if (cmd.clr_step) begin
         head_we = 1'b1;
      end else if (cmd.alloc_head && !full) begin
         head_we = 1'b1;
         head_wa = value_ff[IdxW-1:0];
         head_wd = used_ff;
      end
   end

   // Entry store port.
   always_comb begin
      ent_we = 1'b0;
      ent_wa = cur_ff;
      ent_wd = ent_rd_ff;
      ent_re = cmd.rd_head || cmd.rd_link;
      ent_ra = cmd.rd_head ? head_rd_ff[IdxW-1:0] : ent_rd_ff.link[IdxW-1:0];
      if (cmd.refresh) begin
         ent_we          = 1'b1;
         ent_wd.position = pos_ff;
      end else if (alloc && !full) begin
         ent_we          = 1'b1;
         ent_wa          = used_ff[IdxW-1:0];
         ent_wd.value    = value_ff;
         ent_wd.position = pos_ff;
         ent_wd.link     = Empty;
      end else if (cmd.link_wr) begin
         ent_we      = 1'b1;
         ent_wd.link = alloc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      if (cmd.accept) head_rd_ff <= head_mem[req_value[IdxW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wa] <= ent_wd;
      if (ent_re) ent_rd_ff <= ent_mem[ent_ra];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         value_ff <= req_value;
         last_ff  <= req_last;
         pos_ff   <= counter_ff;
      end
      if (cmd.rd_head) begin
         cur_ff   <= head_rd_ff[IdxW-1:0];
         first_ff <= 1'b1;
      end else if (cmd.rd_link) begin
         cur_ff   <= ent_rd_ff.link[IdxW-1:0];
         first_ff <= 1'b0;
      end
      if (alloc) alloc_ff <= used_ff;
      if (cmd.finish) begin
         rsp_match_ff    <= match_ff;
         rsp_found_ff    <= found_ff || match_ff;
         rsp_overflow_ff <= ovf_ff;
         rsp_done_ff     <= last_ff;
      end
   end

   // Control and sticky state.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_k_ff  <= '0;
         counter_ff   <= '0;
         used_ff      <= '0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         match_ff     <= 1'b0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) window_k_ff <= csr_window_k;
         if (cmd.clr_step) clr_idx_ff <= clr_idx_ff + 1'b1;
         if (cmd.accept) begin
            match_ff <= 1'b0;
            if (counter_ff == PosMax) begin
               ovf_ff <= 1'b1;
            end else begin
               counter_ff <= counter_ff + 1'b1;
            end
         end
         if (cmd.refresh) match_ff <= near;
         if (alloc) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               used_ff <= used_ff + 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
            if (last_ff) begin
               counter_ff <= '0;
               used_ff    <= '0;
               found_ff   <= 1'b0;
               ovf_ff     <= 1'b0;
            end else begin
               found_ff <= found_ff || match_ff;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_match    = rsp_match_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_overflow = rsp_overflow_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

// File: src/nearby_duplicate_detector_top.sv
// Reports, for each value of a stream of signed 32-bit values, whether the same value was
// seen at most window_k positions earlier in the current array, with sticky found and
// overflow flags; the array ends with the transaction that has last set, after which
// the store, the position counter and the flags clear. A hash store of TABLE_ENTRIES
// entries (a power of two; the bucket is the low bits of the value) keeps the last
// position of each distinct value. One item is in work at a time: the bucket head is
// read on acceptance; an empty bucket gets a new entry, a head that still points at an
// entry of an earlier array is read and replaced by a new head, and otherwise the chain
// is walked entry by entry through the one read port of the entry memory until the
// value is found and its position refreshed or a new entry is linked to the chain end.
// A result that is not taken holds the next item back for as long as it waits. After
// reset a clearing pass over all TABLE_ENTRIES bucket heads empties them, and no item is
// accepted during it; window_k may be written at any time the block is idle.
module nearby_duplicate_detector_top
   import nddet_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024,
   parameter int POSITION_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   nddet_req_if.sink  req_ch,
   nddet_rsp_if.source rsp_ch,
   nddet_csr_if.sink  csr_ch
);

   cmd_type    cmd;
   status_type st;

   assign csr_ch.ready = 1'b1;

   nddet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   nddet_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_value    (req_ch.value),
      .req_last     (req_ch.last),
      .csr_valid    (csr_ch.valid),
      .csr_window_k (csr_ch.window_k),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_match    (rsp_ch.match),
      .rsp_found    (rsp_ch.found),
      .rsp_overflow (rsp_ch.overflow),
      .rsp_done_res (rsp_ch.done_res)
   );

endmodule

// File: src/nddet_checker.sv
module nddet_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_match,
   input logic rsp_found,
   input logic rsp_overflow,
   input logic rsp_done_res
);

   // The clearing pass keeps the input closed right after reset.
   a_closed_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input ready right after reset");

   // Only one item is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready in the cycle after a transaction");

   a_found_covers_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_match) |-> rsp_found)
      else $error("match reported without found");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before transaction");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_match) && $stable(rsp_found) && $stable(rsp_overflow)
          && $stable(rsp_done_res)))
      else $error("result changed while stalled");

endmodule

bind nearby_duplicate_detector_top nddet_checker u_nddet_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_match    (rsp_ch.match),
   .rsp_found    (rsp_ch.found),
   .rsp_overflow (rsp_ch.overflow),
   .rsp_done_res (rsp_ch.done_res)
);
